// ----- src/uart_baud_divisor_calc_core_defines.svh -----
// ----------------------------------------------------------------------------
// uart baud divisor calc core - assertion macros
// shared assertion forms used by the checker
// ----------------------------------------------------------------------------
`ifndef UART_BAUD_DIVISOR_CALC_CORE_DEFINES_SVH
`define UART_BAUD_DIVISOR_CALC_CORE_DEFINES_SVH

// same-cycle implication, reset disables the check
`define UBD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ubd same-cycle check failed");

// next-cycle implication, reset disables the check
`define UBD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ubd next-cycle check failed");

`endif

// ----- src/ubd_pkg.sv -----
// ----------------------------------------------------------------------------
// ubd_pkg
// types and constants for the uart baud divisor calculator
// ----------------------------------------------------------------------------
package ubd_pkg;

    localparam int CLK_W          = 28;
    localparam int BAUD_W         = 24;
    localparam int WORD_W         = 16;
    localparam int MANT_W         = 12;
    localparam int FRAC_W         = 4;
    localparam int STATUS_W       = 2;
    localparam int CFG_IDX_W      = 2;

    // 25 * clock needs 33 bits, after the k shift the dividend fits 32
    localparam int PROD_W         = CLK_W + 5;
    localparam int DIV_W          = 32;
    localparam int BITS_PER_STAGE = 4;
    localparam int DIV_STAGES     = DIV_W / BITS_PER_STAGE;

    localparam logic [CLK_W-1:0] CLK_RESET = 28'd16000000;
    localparam logic [4:0]       CLK_SCALE = 5'd25;

    // quotient at or above 4096*100 always overflows the mantissa
    localparam logic [DIV_W-1:0] OVF_LIMIT = 32'd409600;
    localparam int               X_W       = 19;

    // mantissa = x / 100 by reciprocal, exact for x below 2^19
    localparam int               MANT_RCP_W = 20;
    localparam logic [MANT_RCP_W-1:0] MANT_RCP = 20'd671089;
    localparam int               MANT_SHIFT = 26;
    localparam int               MPROD_W    = X_W + MANT_RCP_W;

    localparam int               REM_W      = 7;
    localparam int               Y_W        = 11;
    localparam logic [X_W-1:0]   CENT       = 19'd100;
    localparam logic [Y_W-1:0]   ROUND_HALF = 11'd50;

    // fraction = y / 100 by reciprocal, exact for y below 4681
    localparam logic [Y_W-1:0]   FRAC_RCP   = 11'd1311;
    localparam int               FRAC_SHIFT = 17;
    localparam int               FPROD_W    = 2 * Y_W;

    localparam logic [MANT_W-1:0] MANT_MAX  = 12'hFFF;
    localparam logic [FRAC_W-1:0] FRAC_MAX  = 4'hF;
    localparam logic [WORD_W-1:0] WORD_SAT  = 16'hFFFF;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_ZERO_BAUD = 2'd1,
        ST_OVERFLOW  = 2'd2
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SLOW_CLK = 2'd0,
        CFG_FAST_CLK = 2'd1
    } t_cfg_reg;

    // one item in the divider; quotient bits shift into num from the bottom
    typedef struct packed {
        logic [DIV_W-1:0]  num;
        logic [BAUD_W-1:0] rem;
        logic [BAUD_W-1:0] den;
        logic              by8;
        logic              zero;
    } t_div_item;

endpackage

// ----- src/ubd_div_pipe.sv -----
// ----------------------------------------------------------------------------
// ubd_div_pipe
// pipelined restoring divider, four quotient bits per stage
// ----------------------------------------------------------------------------
module ubd_div_pipe (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  ubd_pkg::t_div_item i_item,
    output logic               o_valid,
    input  logic               i_stall,
    output ubd_pkg::t_div_item o_item
);
    import ubd_pkg::*;

    logic      r_vld [DIV_STAGES];
    t_div_item r_stg [DIV_STAGES];
    logic      w_en  [DIV_STAGES];
    logic      w_src_vld [DIV_STAGES];
    t_div_item w_src [DIV_STAGES];
    t_div_item n_stg [DIV_STAGES];

    function automatic t_div_item div_step(input t_div_item a);
        t_div_item         b;
        logic [BAUD_W:0]   t;
        b = a;
        for (int j = 0; j < BITS_PER_STAGE; j++) begin
            t = {b.rem, b.num[DIV_W-1]};
            if (t >= {1'b0, b.den}) begin
                t = t - {1'b0, b.den};
                b.num = {b.num[DIV_W-2:0], 1'b1};
            end else begin
                b.num = {b.num[DIV_W-2:0], 1'b0};
            end
            b.rem = t[BAUD_W-1:0];
        end
        return b;
    endfunction

    genvar k;
    generate
        for (k = 0; k < DIV_STAGES; k++) begin : g_stage
            if (k == 0) begin : g_first
                assign w_src_vld[k] = i_valid;
                assign w_src[k]     = i_item;
            end else begin : g_next
                assign w_src_vld[k] = r_vld[k-1];
                assign w_src[k]     = r_stg[k-1];
            end

            if (k == DIV_STAGES - 1) begin : g_last_en
                assign w_en[k] = !r_vld[k] || !i_stall;
            end else begin : g_mid_en
                assign w_en[k] = !r_vld[k] || w_en[k+1];
            end

            assign n_stg[k] = div_step(w_src[k]);

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[k] <= 1'b0;
                end else if (w_en[k]) begin
                    r_vld[k] <= w_src_vld[k];
                end
            end

            always_ff @(posedge i_clk) begin
                if (w_en[k]) begin
                    r_stg[k] <= n_stg[k];
                end
            end
        end
    endgenerate

    assign o_stall = !w_en[0];
    assign o_valid = r_vld[DIV_STAGES-1];
    assign o_item  = r_stg[DIV_STAGES-1];

endmodule

// ----- src/uart_baud_divisor_calc_core.sv -----
// ----------------------------------------------------------------------------
// uart_baud_divisor_calc_core
// fractional uart baud divisor from a requested baud rate
// ----------------------------------------------------------------------------
// For each request the core picks the slow or fast bus clock, forms
// usartdiv = 25*clock / (k*baud) with k = 2 for oversampling by 8 and 4 for
// oversampling by 16, splits it into mantissa (usartdiv/100) and a rounded
// fraction in eighths or sixteenths, folds a rounding carry into the
// mantissa and packs mantissa<<4 | fraction. A zero baud rate returns all
// zero with status 1; a mantissa above 4095 saturates to 0xFFFF with
// status 2. Throughput is one transfer per clock unless stalled. One stage
// scales the clock, eight stages run the 32-bit quotient four bits at a
// time, two stages split off the mantissa and fraction by reciprocal
// multiplies, and the last stage is the output register. Stalls back up
// stage by stage, so empty stages keep filling while a result waits. The
// user must write the clock registers through the plain write port only
// while no request is in flight; the core does not enforce it. Both reset
// to 16 MHz and an index beyond the fast clock register is ignored.
// ----------------------------------------------------------------------------
module uart_baud_divisor_calc_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration write port
    input  logic                          i_cfg_we,
    input  logic [ubd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ubd_pkg::CLK_W-1:0]     i_cfg_wdata,
    // request channel
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [ubd_pkg::BAUD_W-1:0]    i_baud_rate,
    input  logic                          i_use_fast_bus,
    input  logic                          i_oversample_by_8,
    // result channel
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [ubd_pkg::WORD_W-1:0]    o_divisor_word,
    output logic [ubd_pkg::MANT_W-1:0]    o_mantissa,
    output logic [ubd_pkg::FRAC_W-1:0]    o_fraction,
    output logic [ubd_pkg::STATUS_W-1:0]  o_status
);
    import ubd_pkg::*;

    // stage payloads after the divider
    typedef struct packed {
        logic [X_W-1:0]     x;
        logic [MPROD_W-1:0] prod;
        logic               by8;
        logic               zero;
        logic               ovf;
    } t_b_item;

    typedef struct packed {
        logic [MANT_W-1:0] mant;
        logic [Y_W-1:0]    y;
        logic              by8;
        logic              zero;
        logic              ovf;
    } t_c_item;

    // clock registers
    logic [CLK_W-1:0] r_slow_clk;
    logic [CLK_W-1:0] r_fast_clk;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slow_clk <= CLK_RESET;
            r_fast_clk <= CLK_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SLOW_CLK: r_slow_clk <= i_cfg_wdata;
                CFG_FAST_CLK: r_fast_clk <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // stall chain, each stage moves when empty or when the next one moves
    logic w_en_a, w_en_b, w_en_c, w_en_d;
    logic w_div_stall;

    logic      r_a_vld;
    t_div_item r_a;
    t_div_item n_a;

    logic      w_div_vld;
    t_div_item w_div_out;

    logic      r_b_vld;
    t_b_item   r_b;
    t_b_item   n_b;

    logic      r_c_vld;
    t_c_item   r_c;
    t_c_item   n_c;

    logic                r_out_vld;
    logic [WORD_W-1:0]   r_word;
    logic [MANT_W-1:0]   r_mant;
    logic [FRAC_W-1:0]   r_frac;
    t_status             r_status;
    logic [WORD_W-1:0]   n_word;
    logic [MANT_W-1:0]   n_mant;
    logic [FRAC_W-1:0]   n_frac;
    t_status             n_status;

    assign w_en_d = !r_out_vld || !i_stall;
    assign w_en_c = !r_c_vld || w_en_d;
    assign w_en_b = !r_b_vld || w_en_c;
    assign w_en_a = !r_a_vld || !w_div_stall;
    assign o_stall = !w_en_a;

    // stage a: clock select, 25*clock, fold k into the dividend
    logic [CLK_W-1:0]  w_clk_sel;
    logic [PROD_W-1:0] w_scaled;

    always_comb begin
        w_clk_sel = i_use_fast_bus ? r_fast_clk : r_slow_clk;
        w_scaled  = {5'd0, w_clk_sel} * {{(PROD_W-5){1'b0}}, CLK_SCALE};
        n_a.num   = i_oversample_by_8 ? w_scaled[PROD_W-1:1]
                                      : {1'b0, w_scaled[PROD_W-1:2]};
        n_a.rem   = '0;
        n_a.den   = i_baud_rate;
        n_a.by8   = i_oversample_by_8;
        n_a.zero  = (i_baud_rate == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (w_en_a) begin
            r_a_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_a) begin
            r_a <= n_a;
        end
    end

    // quotient pipeline
    ubd_div_pipe u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_a_vld),
        .o_stall (w_div_stall),
        .i_item  (r_a),
        .o_valid (w_div_vld),
        .i_stall (!w_en_b),
        .o_item  (w_div_out)
    );

    // stage b: early overflow and x * (2^26/100)
    always_comb begin
        n_b.ovf  = (w_div_out.num >= OVF_LIMIT);
        n_b.x    = w_div_out.num[X_W-1:0];
        n_b.prod = {{MANT_RCP_W{1'b0}}, w_div_out.num[X_W-1:0]}
                 * {{X_W{1'b0}}, MANT_RCP};
        n_b.by8  = w_div_out.by8;
        n_b.zero = w_div_out.zero;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (w_en_b) begin
            r_b_vld <= w_div_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_b) begin
            r_b <= n_b;
        end
    end

    // stage c: mantissa, remainder, scaled remainder plus one half
    logic [X_W-1:0]   w_mant_cent;
    logic [X_W-1:0]   w_rem_full;
    logic [REM_W-1:0] w_rem;
    logic [Y_W-1:0]   w_rem_steps;

    always_comb begin
        n_c.mant    = r_b.prod[MANT_SHIFT+MANT_W-1:MANT_SHIFT];
        w_mant_cent = {{(X_W-MANT_W){1'b0}}, n_c.mant} * CENT;
        w_rem_full  = r_b.x - w_mant_cent;
        w_rem       = w_rem_full[REM_W-1:0];
        w_rem_steps = r_b.by8 ? {1'b0, w_rem, 3'd0} : {w_rem, 4'd0};
        n_c.y       = w_rem_steps + ROUND_HALF;
        n_c.by8     = r_b.by8;
        n_c.zero    = r_b.zero;
        n_c.ovf     = r_b.ovf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else if (w_en_c) begin
            r_c_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_c) begin
            r_c <= n_c;
        end
    end

    // stage d: rounded fraction, carry into mantissa, saturate, pack
    logic [FPROD_W-1:0] w_fprod;
    logic [FRAC_W:0]    w_frac_raw;
    logic               w_carry;
    logic [MANT_W:0]    w_mant_c;
    logic [FRAC_W-1:0]  w_frac;

    always_comb begin
        w_fprod    = {{Y_W{1'b0}}, r_c.y} * {{Y_W{1'b0}}, FRAC_RCP};
        w_frac_raw = w_fprod[FRAC_SHIFT+FRAC_W:FRAC_SHIFT];
        // the rounded fraction never passes the step count, so one bit tells
        w_carry    = r_c.by8 ? w_frac_raw[FRAC_W-1] : w_frac_raw[FRAC_W];
        w_frac     = w_carry ? '0 : w_frac_raw[FRAC_W-1:0];
        w_mant_c   = {1'b0, r_c.mant} + {{MANT_W{1'b0}}, w_carry};

        if (r_c.zero) begin
            n_word   = '0;
            n_mant   = '0;
            n_frac   = '0;
            n_status = ST_ZERO_BAUD;
        end else if (r_c.ovf || w_mant_c[MANT_W]) begin
            n_word   = WORD_SAT;
            n_mant   = MANT_MAX;
            n_frac   = FRAC_MAX;
            n_status = ST_OVERFLOW;
        end else begin
            n_word   = {w_mant_c[MANT_W-1:0], w_frac};
            n_mant   = w_mant_c[MANT_W-1:0];
            n_frac   = w_frac;
            n_status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en_d) begin
            r_out_vld <= r_c_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_d) begin
            r_word   <= n_word;
            r_mant   <= n_mant;
            r_frac   <= n_frac;
            r_status <= n_status;
        end
    end

    assign o_valid        = r_out_vld;
    assign o_divisor_word = r_word;
    assign o_mantissa     = r_mant;
    assign o_fraction     = r_frac;
    assign o_status       = r_status;

endmodule

// ----- src/ubd_checker.sv -----
// ----------------------------------------------------------------------------
// ubd_checker
// port-level checks on the uart baud divisor calculator results
// ----------------------------------------------------------------------------
`include "uart_baud_divisor_calc_core_defines.svh"

module ubd_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_valid,
    input logic                          i_stall,
    input logic [ubd_pkg::WORD_W-1:0]    o_divisor_word,
    input logic [ubd_pkg::MANT_W-1:0]    o_mantissa,
    input logic [ubd_pkg::FRAC_W-1:0]    o_fraction,
    input logic [ubd_pkg::STATUS_W-1:0]  o_status
);
    import ubd_pkg::*;

    logic w_res_zero;
    logic w_res_sat;
    logic w_res_packed;
    logic w_stalled;
    logic [WORD_W+MANT_W+FRAC_W+STATUS_W-1:0] w_res_bus;

    assign w_res_zero   = (o_divisor_word == '0) && (o_mantissa == '0) && (o_fraction == '0);
    assign w_res_sat    = (o_divisor_word == WORD_SAT) && (o_mantissa == MANT_MAX)
                       && (o_fraction == FRAC_MAX);
    assign w_res_packed = (o_divisor_word == {o_mantissa, o_fraction});
    assign w_stalled    = o_valid && i_stall;
    assign w_res_bus    = {o_divisor_word, o_mantissa, o_fraction, o_status};

    // zero baud rate result carries no divisor
    `UBD_ASSERT_IMP(a_zero_baud_clear, i_clk, i_rst_n, o_valid && (o_status == ST_ZERO_BAUD), w_res_zero)

    // overflow saturates every field
    `UBD_ASSERT_IMP(a_overflow_sat, i_clk, i_rst_n, o_valid && (o_status == ST_OVERFLOW), w_res_sat)

    // a good result packs mantissa and fraction into the word
    `UBD_ASSERT_IMP(a_word_packing, i_clk, i_rst_n, o_valid && (o_status == ST_OK), w_res_packed)

    // a stalled result stays put
    `UBD_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, w_stalled, o_valid && $stable(w_res_bus))

endmodule

bind uart_baud_divisor_calc_core ubd_checker u_ubd_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_valid           (o_valid),
    .i_stall           (i_stall),
    .o_divisor_word    (o_divisor_word),
    .o_mantissa        (o_mantissa),
    .o_fraction        (o_fraction),
    .o_status          (o_status)
);

// ----- tb/sv/tb_uart_baud_divisor_calc_core.sv -----
// ----------------------------------------------------------------------------
// tb_uart_baud_divisor_calc_core
// self-checking bench for the uart baud divisor calculator
// ----------------------------------------------------------------------------
// A short table of directed requests runs first at the reset clocks: zero
// baud, saturation, well-known divisor words, the smallest divisors, the
// fraction carry in eighths and sixteenths and both sides of the mantissa
// limit. Rows with an obvious answer carry it typed in; the rest go through
// the bench's own divisor predictor. Then eight phases each rewrite both
// clock registers (extremes, zero, all ones, typical and random values),
// poke the unused register indexes, and send random requests aimed at the
// interesting regions, under four idling patterns. Once, the result side
// holds off for a long stretch so the pipeline fills and stalls its input.
// ----------------------------------------------------------------------------
module tb_uart_baud_divisor_calc_core;

    import ubd_pkg::*;

    localparam int CLK_PERIOD       = 8;
    localparam int RESET_CYCLES     = 5;
    localparam int NUM_PHASES       = 8;
    localparam int ITEMS_PER_PHASE  = 163;
    localparam int HOLD_OFF_PHASE   = 1;
    localparam int HOLD_OFF_CYCLES  = 300;
    localparam int DRAIN_CYCLES     = 30;
    localparam int CYCLE_LIMIT      = 200000;
    localparam int MAX_REPORTS      = 10;
    localparam int NUM_DIRECTED     = 17;

    // register indexes with no register behind them, writes must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

    // quotient at which the mantissa first exceeds its 12 bits
    localparam longint unsigned MANT_LIMIT_QUOT = 64'd409600;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic [MANT_W-1:0] mant;
        logic [FRAC_W-1:0] frac;
        t_status           status;
    } t_divisor_result;

    typedef struct packed {
        logic [BAUD_W-1:0] baud;
        logic              fast;
        logic              by8;
        logic              typed;
        t_divisor_result   want;
    } t_stim_row;

    localparam t_divisor_result UNTYPED          = '{16'h0000, 12'h000, 4'h0, ST_OK};
    localparam t_divisor_result ZERO_BAUD_RESULT = '{16'h0000, 12'h000, 4'h0, ST_ZERO_BAUD};
    localparam t_divisor_result SATURATED_RESULT = '{WORD_SAT, MANT_MAX, FRAC_MAX, ST_OVERFLOW};

    // directed requests, all at the 16 MHz reset clocks
    t_stim_row directed_rows [NUM_DIRECTED] = '{
        '{24'd0,        1'b0, 1'b0, 1'b1, ZERO_BAUD_RESULT},
        '{24'd0,        1'b1, 1'b1, 1'b1, ZERO_BAUD_RESULT},
        '{24'd1,        1'b0, 1'b0, 1'b1, SATURATED_RESULT},
        '{24'd1,        1'b1, 1'b1, 1'b1, SATURATED_RESULT},
        '{24'd115200,   1'b0, 1'b0, 1'b1, '{16'h008B, 12'd8, 4'd11, ST_OK}},
        '{24'd9600,     1'b1, 1'b0, 1'b1, '{16'h0683, 12'd104, 4'd3, ST_OK}},
        '{24'd115200,   1'b1, 1'b1, 1'b0, UNTYPED},
        '{24'hFFFFFF,   1'b0, 1'b1, 1'b0, UNTYPED},   // mantissa zero, eighths
        '{24'hFFFFFF,   1'b1, 1'b0, 1'b0, UNTYPED},   // mantissa zero, sixteenths
        '{24'd12000000, 1'b0, 1'b1, 1'b0, UNTYPED},
        '{24'd91157,    1'b0, 1'b0, 1'b0, UNTYPED},   // sixteenths round up into mantissa
        '{24'd182815,   1'b1, 1'b1, 1'b0, UNTYPED},   // eighths round up into mantissa
        '{24'd244,      1'b0, 1'b0, 1'b0, UNTYPED},   // mantissa just over the limit
        '{24'd245,      1'b1, 1'b0, 1'b0, UNTYPED},   // mantissa just under the limit
        '{24'h555555,   1'b0, 1'b1, 1'b0, UNTYPED},
        '{24'hAAAAAA,   1'b1, 1'b0, 1'b0, UNTYPED},
        '{24'd2,        1'b0, 1'b1, 1'b0, UNTYPED}
    };

    int unsigned common_bauds [16] = '{
        1200, 2400, 4800, 9600, 19200, 38400, 57600, 115200, 230400,
        460800, 921600, 2000000, 3000000, 4500000, 6000000, 12000000
    };
    int unsigned typical_clocks [8] = '{
        8000000, 16000000, 42000000, 45000000, 84000000, 90000000,
        168000000, 180000000
    };

    // dut ports
    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CLK_W-1:0]      i_cfg_wdata;
    logic                  i_valid;
    logic                  o_stall;
    logic [BAUD_W-1:0]     i_baud_rate;
    logic                  i_use_fast_bus;
    logic                  i_oversample_by_8;
    logic                  o_valid;
    logic                  i_stall;
    logic [WORD_W-1:0]     o_divisor_word;
    logic [MANT_W-1:0]     o_mantissa;
    logic [FRAC_W-1:0]     o_fraction;
    logic [STATUS_W-1:0]   o_status;

    // shadow copy of the clock registers
    logic [CLK_W-1:0]      slow_clk_hz;
    logic [CLK_W-1:0]      fast_clk_hz;

    t_divisor_result       pending_divisors [$];
    t_divisor_result       oldest_divisor;
    int                    fail_count;
    int                    cycle_count;
    int                    send_idle_pct;
    int                    recv_stall_pct;
    logic                  hold_off_req;
    int                    hold_off_left;
    int                    row;
    int                    ph;

    uart_baud_divisor_calc_core uut (.*);

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // divisor predictor: exact 64-bit arithmetic on the shadow clocks
    function automatic t_divisor_result predict_divisor(input logic [BAUD_W-1:0] baud,
                                                        input logic fast,
                                                        input logic by8);
        longint unsigned clk_hz;
        longint unsigned quot;
        longint unsigned mant;
        longint unsigned rem;
        longint unsigned steps;
        longint unsigned frac;
        t_divisor_result res;
        clk_hz = fast ? fast_clk_hz : slow_clk_hz;
        if (baud == '0) begin
            return ZERO_BAUD_RESULT;
        end
        quot  = (64'd25 * clk_hz) / ((by8 ? 64'd2 : 64'd4) * baud);
        mant  = quot / 64'd100;
        rem   = quot - mant * 64'd100;
        steps = by8 ? 64'd8 : 64'd16;
        frac  = (rem * steps + 64'd50) / 64'd100;
        // rounding all the way up moves into the mantissa
        if (frac >= steps) begin
            frac = 0;
            mant = mant + 1;
        end
        if (mant > MANT_MAX) begin
            return SATURATED_RESULT;
        end
        res.word   = {mant[MANT_W-1:0], frac[FRAC_W-1:0]};
        res.mant   = mant[MANT_W-1:0];
        res.frac   = frac[FRAC_W-1:0];
        res.status = ST_OK;
        return res;
    endfunction

    // random baud rate, weighted toward the regions where the math turns
    function automatic logic [BAUD_W-1:0] pick_baud(input logic fast, input logic by8);
        int unsigned     sel;
        longint          near_limit;
        longint unsigned clk_hz;
        sel = $urandom_range(99);
        clk_hz = fast ? fast_clk_hz : slow_clk_hz;
        if (sel < 4) begin
            return '0;
        end else if (sel < 12) begin
            return BAUD_W'($urandom_range(24'hFFFFFF, 0));
        end else if (sel < 25) begin
            return BAUD_W'($urandom_range(2000, 1));
        end else if (sel < 45) begin
            // a few steps around the baud that puts the mantissa at its limit
            near_limit = longint'((64'd25 * clk_hz) / ((by8 ? 64'd2 : 64'd4) * MANT_LIMIT_QUOT));
            near_limit = near_limit + longint'($urandom_range(6)) - 3;
            if (near_limit < 1) near_limit = 1;
            return near_limit[BAUD_W-1:0];
        end else if (sel < 65) begin
            return BAUD_W'(common_bauds[4'($urandom_range(15))]);
        end else begin
            return BAUD_W'($urandom_range(12000000, 300));
        end
    endfunction

    function automatic logic [CLK_W-1:0] pick_clock();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 15) begin
            return CLK_W'($urandom);     // truncated to the full 28-bit range
        end else if (sel < 55) begin
            return CLK_W'(typical_clocks[3'($urandom_range(7))]);
        end else begin
            return CLK_W'($urandom_range(180000000, 1));
        end
    endfunction

    // enter and leave at a falling edge; write enable is lowered by the caller
    task automatic write_clock_reg(input logic [CFG_IDX_W-1:0] idx,
                                   input logic [CLK_W-1:0] value);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_wdata = value;
        @(posedge i_clk);
        case (idx)
            CFG_SLOW_CLK: slow_clk_hz = value;
            CFG_FAST_CLK: fast_clk_hz = value;
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    // one request transfer; the expectation is queued at the accepting edge
    task automatic send_request(input logic [BAUD_W-1:0] baud, input logic fast,
                                input logic by8, input logic typed,
                                input t_divisor_result typed_want);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid           = 1'b1;
        i_baud_rate       = baud;
        i_use_fast_bus    = fast;
        i_oversample_by_8 = by8;
        do @(posedge i_clk); while (o_stall);
        pending_divisors.push_back(typed ? typed_want : predict_divisor(baud, fast, by8));
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        while (pending_divisors.size() != 0) @(negedge i_clk);
    endtask

    // result side stall, with the one long hold-off counted here
    always @(negedge i_clk) begin
        if (hold_off_req) begin
            hold_off_left = HOLD_OFF_CYCLES;
            hold_off_req  = 1'b0;
        end
        if (hold_off_left > 0) begin
            i_stall       = 1'b1;
            hold_off_left = hold_off_left - 1;
        end else begin
            i_stall = ($urandom_range(99) < recv_stall_pct);
        end
    end

    // result checker, oldest expectation first
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_divisors.size() == 0) begin
                fail_count = fail_count + 1;
                if (fail_count <= MAX_REPORTS)
                    $display("unexpected result: word %h mant %0d frac %0d status %0d",
                             o_divisor_word, o_mantissa, o_fraction, o_status);
            end else begin
                oldest_divisor = pending_divisors.pop_front();
                if (o_divisor_word !== oldest_divisor.word
                        || o_mantissa !== oldest_divisor.mant
                        || o_fraction !== oldest_divisor.frac
                        || o_status !== oldest_divisor.status) begin
                    fail_count = fail_count + 1;
                    if (fail_count <= MAX_REPORTS) begin
                        $write("mismatch: expected word %h mant %0d frac %0d status %0d, ",
                               oldest_divisor.word, oldest_divisor.mant,
                               oldest_divisor.frac, oldest_divisor.status);
                        $display("got word %h mant %0d frac %0d status %0d",
                                 o_divisor_word, o_mantissa, o_fraction, o_status);
                    end
                end
            end
        end
    end

    // runaway guard
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        i_clk             = 1'b0;
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_index       = CFG_SLOW_CLK;
        i_cfg_wdata       = '0;
        i_valid           = 1'b0;
        i_baud_rate       = '0;
        i_use_fast_bus    = 1'b0;
        i_oversample_by_8 = 1'b0;
        i_stall           = 1'b0;
        slow_clk_hz       = CLK_RESET;
        fast_clk_hz       = CLK_RESET;
        fail_count        = 0;
        cycle_count       = 0;
        send_idle_pct     = 0;
        recv_stall_pct    = 0;
        hold_off_req      = 1'b0;
        hold_off_left     = 0;

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed table at the reset clocks, no idling
        for (row = 0; row < NUM_DIRECTED; row++) begin
            send_request(directed_rows[row].baud, directed_rows[row].fast,
                         directed_rows[row].by8, directed_rows[row].typed,
                         directed_rows[row].want);
        end

        for (ph = 1; ph <= NUM_PHASES; ph++) begin
            // registers only change with the pipeline empty
            i_valid = 1'b0;
            wait_drained();
            case (ph)
                1: begin
                    write_clock_reg(CFG_SLOW_CLK, 28'd180000000);
                    write_clock_reg(CFG_FAST_CLK, 28'd1);
                end
                2: begin
                    write_clock_reg(CFG_SLOW_CLK, 28'd1);
                    write_clock_reg(CFG_FAST_CLK, 28'd180000000);
                end
                3: begin
                    // zero clock gives an all-zero word, all ones the largest dividend
                    write_clock_reg(CFG_SLOW_CLK, 28'd0);
                    write_clock_reg(CFG_FAST_CLK, 28'hFFFFFFF);
                end
                4: begin
                    write_clock_reg(CFG_SLOW_CLK, 28'd42000000);
                    write_clock_reg(CFG_FAST_CLK, 28'd84000000);
                end
                default: begin
                    write_clock_reg(CFG_SLOW_CLK, pick_clock());
                    write_clock_reg(CFG_FAST_CLK, pick_clock());
                end
            endcase
            // unused indexes must leave both clocks alone
            write_clock_reg((ph % 2) ? CFG_SPARE_LO : CFG_SPARE_HI, CLK_W'($urandom));
            i_cfg_we = 1'b0;

            case ((ph - 1) % 4)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 82;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 82;
                end
                default: begin
                    send_idle_pct  = 36;
                    recv_stall_pct = 36;
                end
            endcase
            // long hold-off on the result side while requests keep coming
            if (ph == HOLD_OFF_PHASE) hold_off_req = 1'b1;

            repeat (ITEMS_PER_PHASE) begin
                logic fast;
                logic by8;
                fast = 1'($urandom_range(1));
                by8  = 1'($urandom_range(1));
                send_request(pick_baud(fast, by8), fast, by8, 1'b0, UNTYPED);
            end
        end

        i_valid = 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (pending_divisors.size() != 0) begin
            fail_count = fail_count + pending_divisors.size();
            $display("results missing: %0d", pending_divisors.size());
        end

        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
